FILE: src/assert_macros.svh
// Assertion macros shared by the display power manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: src/dpm_pkg.sv
// Types, constants and helper functions for the display power manager.
package dpm_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 31;

  localparam logic [31:0] AbortMs   = 32'd2000;
  localparam logic [4:0]  BrightMax = 5'd16;
  localparam logic [4:0]  BrightMin = 5'd1;

  localparam logic [CfgIndexW-1:0] REG_BOOST_WINDOW = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_BRIGHT_HIGH  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_BRIGHT_LOW   = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_CLOSE_RADIUS = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_IDLE_SLEEP   = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_HOLD         = 3'd5;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] SLEEP_NONE   = 2'd0;
  localparam logic [1:0] SLEEP_TOUCH  = 2'd1;
  localparam logic [1:0] SLEEP_BUTTON = 2'd2;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_WAIT   = 3'b010,
    PH_ASLEEP = 3'b100
  } phase_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] now_ms;
    logic        display_ready;
    logic        touched;
    logic        charging;
    logic        button_pressed;
    logic        shown_valid;
    logic        distance_valid;
    logic [15:0] distance_tenths;
    logic        military;
    logic [7:0]  current_brightness;
  } item_t;

  typedef struct packed {
    logic       set_brightness;
    logic [4:0] brightness;
    logic [1:0] sleep_request;
    logic       sleep_aborted;
  } result_t;

  function automatic logic [4:0] clamp_level(input logic [7:0] v);
    logic [4:0] r;
    if (v == 8'd0) begin
      r = BrightMin;
    end else if (v > {3'd0, BrightMax}) begin
      r = BrightMax;
    end else begin
      r = v[4:0];
    end
    return r;
  endfunction

endpackage

FILE: src/display_power_manager_unit.sv
// Display power manager: brightness selection and sleep requests per tick.
// Each item is registered in the stage register, then its result in the result register.
// Throughput: one item per cycle while out_ready does not stall the output.
// Reset: synchronous rst clears both stages, all timers and flags, and restores
// the register defaults (boost 0, high 16, low 1, radius 0, idle 0, hold 0).
`include "assert_macros.svh"

module display_power_manager_unit
  import dpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [31:0]          now_ms,
  input  logic                 display_ready,
  input  logic                 touched,
  input  logic                 charging,
  input  logic                 button_pressed,
  input  logic                 shown_valid,
  input  logic                 distance_valid,
  input  logic [15:0]          distance_tenths,
  input  logic                 military,
  input  logic [7:0]           current_brightness,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 set_brightness,
  output logic [4:0]           brightness,
  output logic [1:0]           sleep_request,
  output logic                 sleep_aborted
);

  logic [30:0] boost_window_ms;
  logic [7:0]  bright_high;
  logic [7:0]  bright_low;
  logic [15:0] close_radius_tenths;
  logic [30:0] idle_sleep_ms;
  logic [30:0] hold_ms;

  logic [31:0] last_touch_time, last_touch_time_next;
  logic [31:0] boost_until, boost_until_next;
  logic        boost_valid, boost_valid_next;
  logic [7:0]  applied_brightness, applied_brightness_next;
  logic [31:0] hold_start, hold_start_next;
  logic        hold_valid, hold_valid_next;
  logic [31:0] release_start, release_start_next;
  phase_t      phase, phase_next;

  item_t   stage;
  logic    stage_valid;
  result_t res, res_next;
  logic    res_valid;
  logic    advance;

  logic [31:0] boost_diff;
  logic [31:0] idle_diff;
  logic [31:0] hold_diff;
  logic [31:0] wait_diff;
  logic [31:0] abort_diff;
  logic [31:0] hold_ref;
  logic        boost_on;
  logic        close_on;
  logic        mil_on;
  logic [4:0]  target;

  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  assign out_valid      = res_valid;
  assign set_brightness = res.set_brightness;
  assign brightness     = res.brightness;
  assign sleep_request  = res.sleep_request;
  assign sleep_aborted  = res.sleep_aborted;

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_window_ms     <= '0;
      bright_high         <= 8'd16;
      bright_low          <= 8'd1;
      close_radius_tenths <= '0;
      idle_sleep_ms       <= '0;
      hold_ms             <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BOOST_WINDOW: boost_window_ms     <= cfg_data;
        REG_BRIGHT_HIGH:  bright_high         <= cfg_data[7:0];
        REG_BRIGHT_LOW:   bright_low          <= cfg_data[7:0];
        REG_CLOSE_RADIUS: close_radius_tenths <= cfg_data[15:0];
        REG_IDLE_SLEEP:   idle_sleep_ms       <= cfg_data;
        REG_HOLD:         hold_ms             <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.operation          <= operation;
      stage.now_ms             <= now_ms;
      stage.display_ready      <= display_ready;
      stage.touched            <= touched;
      stage.charging           <= charging;
      stage.button_pressed     <= button_pressed;
      stage.shown_valid        <= shown_valid;
      stage.distance_valid     <= distance_valid;
      stage.distance_tenths    <= distance_tenths;
      stage.military           <= military;
      stage.current_brightness <= current_brightness;
    end
  end

  always_comb begin
    last_touch_time_next    = last_touch_time;
    boost_until_next        = boost_until;
    boost_valid_next        = boost_valid;
    applied_brightness_next = applied_brightness;
    hold_start_next         = hold_start;
    hold_valid_next         = hold_valid;
    release_start_next      = release_start;
    phase_next              = phase;
    res_next                = '0;

    wait_diff  = stage.now_ms - release_start;
    abort_diff = AbortMs - wait_diff;

    if (stage.touched && (boost_window_ms != '0)) begin
      boost_until_next = stage.now_ms + {1'b0, boost_window_ms};
      boost_valid_next = 1'b1;
      boost_diff       = {1'b0, boost_window_ms};
    end else begin
      boost_diff       = boost_until - stage.now_ms;
    end
    boost_on   = boost_valid_next && (boost_diff != '0) && !boost_diff[31];
    close_on   = stage.shown_valid && stage.distance_valid &&
                 (stage.distance_tenths <= close_radius_tenths);
    mil_on     = stage.shown_valid && stage.military;
    target     = clamp_level((boost_on || close_on || mil_on) ? bright_high : bright_low);

    idle_diff = stage.now_ms - (stage.touched ? stage.now_ms : last_touch_time);
    hold_ref  = hold_valid ? hold_start : stage.now_ms;
    hold_diff = stage.now_ms - hold_ref;

    if (stage.operation == OP_INIT) begin
      boost_until_next        = boost_until;
      boost_valid_next        = boost_valid;
      last_touch_time_next    = stage.now_ms;
      applied_brightness_next = stage.current_brightness;
    end else if (stage.display_ready && (phase == PH_WAIT)) begin
      boost_until_next = boost_until;
      boost_valid_next = boost_valid;
      if (!stage.button_pressed) begin
        res_next.sleep_request = SLEEP_BUTTON;
        phase_next             = PH_ASLEEP;
      end else if (abort_diff[31]) begin
        res_next.sleep_aborted = 1'b1;
        hold_start_next        = '0;
        hold_valid_next        = 1'b0;
        phase_next             = PH_NORMAL;
      end
    end else if (stage.display_ready && (phase == PH_NORMAL)) begin
      if (stage.touched) begin
        last_touch_time_next = stage.now_ms;
      end
      if ({3'd0, target} != applied_brightness) begin
        res_next.set_brightness = 1'b1;
        res_next.brightness     = target;
        applied_brightness_next = {3'd0, target};
      end
      if ((idle_sleep_ms != '0) && !stage.charging && !idle_diff[31] &&
          (idle_diff[30:0] >= idle_sleep_ms)) begin
        res_next.sleep_request = SLEEP_TOUCH;
        phase_next             = PH_ASLEEP;
      end else if (stage.button_pressed) begin
        hold_start_next = hold_ref;
        hold_valid_next = 1'b1;
        if (!hold_diff[31] && (hold_diff[30:0] >= hold_ms)) begin
          release_start_next = stage.now_ms;
          phase_next         = PH_WAIT;
        end
      end else begin
        hold_start_next = '0;
        hold_valid_next = 1'b0;
      end
    end else begin
      boost_until_next = boost_until;
      boost_valid_next = boost_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid        <= 1'b0;
      res_valid          <= 1'b0;
      last_touch_time    <= '0;
      boost_until        <= '0;
      boost_valid        <= 1'b0;
      applied_brightness <= '0;
      hold_start         <= '0;
      hold_valid         <= 1'b0;
      release_start      <= '0;
      phase              <= PH_NORMAL;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (advance) begin
        res_valid          <= 1'b1;
        last_touch_time    <= last_touch_time_next;
        boost_until        <= boost_until_next;
        boost_valid        <= boost_valid_next;
        applied_brightness <= applied_brightness_next;
        hold_start         <= hold_start_next;
        hold_valid         <= hold_valid_next;
        release_start      <= release_start_next;
        phase              <= phase_next;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  `ASSERT_NEXT(a_asleep_holds, clk, rst, phase == PH_ASLEEP, phase == PH_ASLEEP)
  `ASSERT_NEXT(a_sleep_enters_asleep, clk, rst,
    advance && (res_next.sleep_request != SLEEP_NONE), phase == PH_ASLEEP)
  `ASSERT_SAME(a_level_in_range, clk, rst, res_valid && res.set_brightness,
    (res.brightness >= BrightMin) && (res.brightness <= BrightMax))

endmodule

FILE: verif/display_power_manager_unit_test.sv
`timescale 1ns / 1ps
// Testbench for the display power manager: random and directed ticks checked against a predictor.
module display_power_manager_unit_test;
  import dpm_pkg::*;

  localparam int Chunks = 8;
  localparam int ChunkItems = 88;
  localparam int QuietLimit = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [31:0] now_ms = '0;
  logic display_ready = 1'b0;
  logic touched = 1'b0;
  logic charging = 1'b0;
  logic button_pressed = 1'b0;
  logic shown_valid = 1'b0;
  logic distance_valid = 1'b0;
  logic [15:0] distance_tenths = '0;
  logic military = 1'b0;
  logic [7:0] current_brightness = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic set_brightness;
  logic [4:0] brightness;
  logic [1:0] sleep_request;
  logic sleep_aborted;

  display_power_manager_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .now_ms(now_ms), .display_ready(display_ready),
    .touched(touched), .charging(charging), .button_pressed(button_pressed),
    .shown_valid(shown_valid), .distance_valid(distance_valid),
    .distance_tenths(distance_tenths), .military(military),
    .current_brightness(current_brightness),
    .out_valid(out_valid), .out_ready(out_ready),
    .set_brightness(set_brightness), .brightness(brightness),
    .sleep_request(sleep_request), .sleep_aborted(sleep_aborted)
  );

  item_t sample_queue[$];
  result_t action_queue[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int made = 0;
  logic [31:0] clock_ms = '0;

  logic [30:0] cfg_boost = '0;
  logic [7:0] cfg_high = 8'd16;
  logic [7:0] cfg_low = 8'd1;
  logic [15:0] cfg_radius = '0;
  logic [30:0] cfg_idle = '0;
  logic [30:0] cfg_hold = '0;

  logic [31:0] touch_ms = '0;
  logic [31:0] boost_end = '0;
  logic boost_armed = 1'b0;
  logic [7:0] level = '0;
  logic [31:0] press_ms = '0;
  logic press_armed = 1'b0;
  logic [31:0] wait_ms = '0;
  phase_t power_mode = PH_NORMAL;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [4:0] fit_level(input logic [7:0] v);
    if (v == 8'd0) return BrightMin;
    if (v > 8'd16) return BrightMax;
    return v[4:0];
  endfunction

  task automatic predict_actions(input item_t s, output result_t r);
    logic [31:0] span;
    logic [31:0] lead;
    logic boosted;
    logic near;
    logic [4:0] want;
    r = '0;
    if (s.operation == OP_INIT) begin
      touch_ms = s.now_ms;
      level = s.current_brightness;
    end else if (s.display_ready && power_mode == PH_WAIT) begin
      lead = AbortMs - (s.now_ms - wait_ms);
      if (!s.button_pressed) begin
        r.sleep_request = SLEEP_BUTTON;
        power_mode = PH_ASLEEP;
      end else if (lead[31]) begin
        r.sleep_aborted = 1'b1;
        press_ms = '0;
        press_armed = 1'b0;
        power_mode = PH_NORMAL;
      end
    end else if (s.display_ready && power_mode == PH_NORMAL) begin
      if (s.touched) begin
        touch_ms = s.now_ms;
        if (cfg_boost != 0) begin
          boost_end = s.now_ms + {1'b0, cfg_boost};
          boost_armed = 1'b1;
        end
      end
      lead = boost_end - s.now_ms;
      boosted = boost_armed && lead != 0 && !lead[31];
      near = s.shown_valid && s.distance_valid && s.distance_tenths <= cfg_radius;
      want = fit_level((boosted || near || (s.shown_valid && s.military)) ? cfg_high : cfg_low);
      if (level != {3'd0, want}) begin
        r.set_brightness = 1'b1;
        r.brightness = want;
        level = {3'd0, want};
      end
      span = s.now_ms - touch_ms;
      if (cfg_idle != 0 && !s.charging && !span[31] && span >= {1'b0, cfg_idle}) begin
        r.sleep_request = SLEEP_TOUCH;
        power_mode = PH_ASLEEP;
      end else if (s.button_pressed) begin
        if (!press_armed) begin
          press_ms = s.now_ms;
          press_armed = 1'b1;
        end
        span = s.now_ms - press_ms;
        if (!span[31] && span >= {1'b0, cfg_hold}) begin
          wait_ms = s.now_ms;
          power_mode = PH_WAIT;
        end
      end else begin
        press_ms = '0;
        press_armed = 1'b0;
      end
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // driver: hold the payload until the transfer, then load the next sample
  always @(posedge clk) begin : drive_samples
    item_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s = sample_queue.pop_front();
        in_valid <= 1'b1;
        operation <= s.operation;
        now_ms <= s.now_ms;
        display_ready <= s.display_ready;
        touched <= s.touched;
        charging <= s.charging;
        button_pressed <= s.button_pressed;
        shown_valid <= s.shown_valid;
        distance_valid <= s.distance_valid;
        distance_tenths <= s.distance_tenths;
        military <= s.military;
        current_brightness <= s.current_brightness;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_transfers
    item_t seen;
    result_t got;
    result_t want;
    result_t act;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {set_brightness, brightness, sleep_request, sleep_aborted};
        if (action_queue.size() == 0) begin
          $error("result transfer with no action expected");
          mismatches++;
        end else begin
          want = action_queue.pop_front();
          compare_field("set_brightness", want.set_brightness, got.set_brightness);
          compare_field("brightness", want.brightness, got.brightness);
          compare_field("sleep_request", want.sleep_request, got.sleep_request);
          compare_field("sleep_aborted", want.sleep_aborted, got.sleep_aborted);
        end
      end
      if (in_valid && in_ready) begin
        seen = {operation, now_ms, display_ready, touched, charging, button_pressed,
                shown_valid, distance_valid, distance_tenths, military, current_brightness};
        predict_actions(seen, act);
        action_queue.push_back(act);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (sample_queue.size() != 0 || in_valid || action_queue.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [30:0] val);
    case (idx)
      REG_BOOST_WINDOW: cfg_boost = val;
      REG_BRIGHT_HIGH:  cfg_high = val[7:0];
      REG_BRIGHT_LOW:   cfg_low = val[7:0];
      REG_CLOSE_RADIUS: cfg_radius = val[15:0];
      REG_IDLE_SLEEP:   cfg_idle = val;
      REG_HOLD:         cfg_hold = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_idling(input int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  task automatic add(input item_t s);
    sample_queue.push_back(s);
    made++;
  endtask

  task automatic put(input logic op, input logic [31:0] at, input logic ready, input logic touch,
                     input logic btn, input logic shown, input logic dv, input logic [15:0] tenths,
                     input logic mil, input logic [7:0] lvl);
    item_t s;
    s = '0;
    s.operation = op;
    s.now_ms = at;
    s.display_ready = ready;
    s.touched = touch;
    s.button_pressed = btn;
    s.shown_valid = shown;
    s.distance_valid = dv;
    s.distance_tenths = tenths;
    s.military = mil;
    s.current_brightness = lvl;
    add(s);
  endtask

  function automatic item_t rand_tick(input logic [31:0] at, input logic btn);
    item_t s;
    s = '0;
    s.operation = OP_TICK;
    s.now_ms = at;
    s.display_ready = 1'b1;
    s.touched = ($urandom_range(0, 3) == 0);
    s.charging = 1'($urandom_range(0, 1));
    s.button_pressed = btn;
    s.shown_valid = 1'($urandom_range(0, 1));
    s.distance_valid = ($urandom_range(0, 4) != 0);
    s.distance_tenths = 16'($urandom_range(0, 1) ? $urandom_range(0, 3000)
                                                  : $urandom_range(0, 65535));
    s.military = ($urandom_range(0, 4) == 0);
    s.current_brightness = 8'($urandom_range(0, 1) ? $urandom_range(0, 20)
                                                   : $urandom_range(0, 255));
    return s;
  endfunction

  function automatic logic [7:0] pick_level();
    return 8'($urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 255));
  endfunction

  task automatic advance(input int unsigned lo, input int unsigned hi);
    clock_ms = clock_ms + $urandom_range(lo, hi);
  endtask

  // drop in ignored ticks and inits between the ticks of a sequence
  task automatic sprinkle();
    item_t s;
    if ($urandom_range(0, 5) == 0) begin
      s = rand_tick($urandom, 1'($urandom_range(0, 1)));
      s.display_ready = 1'b0;
      add(s);
    end
    if ($urandom_range(0, 9) == 0) begin
      s = rand_tick(clock_ms, 1'($urandom_range(0, 1)));
      s.operation = OP_INIT;
      add(s);
    end
  endtask

  // press the button; either release early or hold past the threshold into an abort
  task automatic hold_run();
    logic [31:0] start;
    logic [31:0] lead;
    int unsigned delta;
    int presses;
    advance(1, 50);
    start = clock_ms;
    if (cfg_hold == 0 || (cfg_hold <= 6000 && $urandom_range(0, 3) != 0)) begin
      add(rand_tick(clock_ms, 1'b1));
      while (clock_ms - start < {1'b0, cfg_hold}) begin
        sprinkle();
        advance(1, 400);
        add(rand_tick(clock_ms, 1'b1));
      end
      start = clock_ms;
      do begin
        sprinkle();
        advance(100, 700);
        add(rand_tick(clock_ms, 1'b1));
        lead = AbortMs - (clock_ms - start);
      end while (!lead[31]);
    end else begin
      presses = $urandom_range(1, 6);
      add(rand_tick(clock_ms, 1'b1));
      for (int i = 1; i < presses; i++) begin
        delta = $urandom_range(1, 400);
        if (clock_ms + delta - start >= {1'b0, cfg_hold}) break;
        clock_ms = clock_ms + delta;
        sprinkle();
        add(rand_tick(clock_ms, 1'b1));
      end
    end
    advance(1, 300);
    add(rand_tick(clock_ms, 1'b0));
  endtask

  task automatic random_run();
    item_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      s = rand_tick($urandom, 1'b0);
      if ($urandom_range(0, 3) == 0) s.operation = OP_INIT;
      s.display_ready = ($urandom_range(0, 7) != 0);
      add(s);
    end else if (pick < 50) begin
      if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
      repeat ($urandom_range(1, 6)) begin
        advance(0, 300);
        add(rand_tick(clock_ms, 1'b0));
        sprinkle();
      end
    end else begin
      hold_run();
    end
  endtask

  task automatic configure(input int k);
    case (k)
      1: begin
        write_reg(REG_BOOST_WINDOW, 31'h7FFF_FFFF);
        write_reg(REG_BRIGHT_HIGH, 31'd255);
        write_reg(REG_BRIGHT_LOW, 31'd255);
        write_reg(REG_CLOSE_RADIUS, 31'd65535);
        write_reg(REG_IDLE_SLEEP, 31'h7FFF_FFFF);
        write_reg(REG_HOLD, 31'h7FFF_FFFF);
      end
      2: begin
        write_reg(REG_BOOST_WINDOW, 31'd0);
        write_reg(REG_BRIGHT_HIGH, 31'd0);
        write_reg(REG_BRIGHT_LOW, 31'd0);
        write_reg(REG_CLOSE_RADIUS, 31'd0);
        write_reg(REG_IDLE_SLEEP, 31'd0);
        write_reg(REG_HOLD, 31'd0);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_BOOST_WINDOW, 31'd0);
          1: write_reg(REG_BOOST_WINDOW, 31'($urandom_range(1, 50)));
          2: write_reg(REG_BOOST_WINDOW, 31'($urandom_range(100, 3000)));
          default: write_reg(REG_BOOST_WINDOW, 31'($urandom_range(0, 32'h7FFF_FFFF)));
        endcase
        write_reg(REG_BRIGHT_HIGH, 31'(pick_level()));
        write_reg(REG_BRIGHT_LOW, 31'(pick_level()));
        write_reg(REG_CLOSE_RADIUS,
                  31'($urandom_range(0, 1) ? $urandom_range(0, 3000)
                                           : $urandom_range(0, 65535)));
        write_reg(REG_IDLE_SLEEP, ($urandom_range(0, 3) == 0) ? 31'h7FFF_FFFF : 31'd0);
        write_reg(REG_HOLD, 31'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                            : $urandom_range(0, 4000)));
      end
    endcase
  endtask

  initial begin
    item_t s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // default registers: brightness picks, init, button wait and abort, wrap of time
    put(OP_TICK, 32'd50, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 1'b1, 8'd9);
    put(OP_INIT, 32'd100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd200, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd300, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd400, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b1, 8'd0);
    put(OP_TICK, 32'd500, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd600, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 1'b0, 8'd0);
    put(OP_TICK, 32'd700, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd800, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1, 8'd0);
    put(OP_TICK, 32'd900, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_INIT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'hFF);
    put(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd1000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd2500, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_INIT, 32'd2600, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd7);
    put(OP_TICK, 32'd2700, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd3000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd3001, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'd3100, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'h0000_06D0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'h0000_06D1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    put(OP_TICK, 32'h0000_0700, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 8'd0);
    clock_ms = 32'h0000_0800;

    for (int k = 0; k < Chunks; k++) begin
      drain();
      configure(k);
      set_idling(k);
      if (k == 3) begin
        clock_ms = 32'hFFFF_F000;
      end else if (k % 3 == 0) begin
        clock_ms = $urandom;
      end
      made = 0;
      while (made < ChunkItems) random_run();
    end

    // finish asleep, by idle timeout or by button release
    drain();
    set_idling(3);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_IDLE_SLEEP, 31'd1500);
      s = rand_tick(clock_ms, 1'b0);
      s.touched = 1'b1;
      s.charging = 1'b0;
      add(s);
      for (int i = 1; i <= 4; i++) begin
        s = rand_tick(clock_ms + ((i < 3) ? i * 500 : 1500 + i * 100), 1'b0);
        s.touched = 1'b0;
        s.charging = (i == 3);
        s.shown_valid = (i == 4) ? 1'b1 : s.shown_valid;
        s.military = (i == 4) ? 1'b1 : s.military;
        add(s);
      end
    end else begin
      write_reg(REG_IDLE_SLEEP, 31'd0);
      write_reg(REG_HOLD, 31'd800);
      for (int i = 0; i < 4; i++) add(rand_tick(clock_ms + i * 400, 1'b1));
      add(rand_tick(clock_ms + 1500, 1'b0));
    end
    repeat (8) begin
      s = rand_tick($urandom, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) s.operation = OP_INIT;
      add(s);
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && action_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/dpm_pkg.sv
src/display_power_manager_unit.sv
verif/display_power_manager_unit_test.sv
